>>> hdl/yuyv_to_rgb_decimating_macros.svh
// ----------------------------------------------------------------------------
// yuyv_to_rgb_decimating_macros
// assertion macros used by the converter top level
// ----------------------------------------------------------------------------
`ifndef YUYV_TO_RGB_DECIMATING_MACROS_SVH
`define YUYV_TO_RGB_DECIMATING_MACROS_SVH

`ifndef ASSERT_OFF

`define YRGB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define YRGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define YRGB_ASSERT_SAME(lbl, ante, cons, msg)

`define YRGB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hdl/yrgb_pkg.sv
// ----------------------------------------------------------------------------
// yrgb_pkg
// types and constants of the yuyv to rgb converter
// ----------------------------------------------------------------------------
package yrgb_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned DEC_W     = 4;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned ROWCNT_W  = 13;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0]    MAX_LINE_WORDS = 13'd4096;
  localparam logic [CFG_W-1:0]    MAX_ROWS       = 13'd4096;
  localparam logic [CFG_W-1:0]    MAX_WIDTH      = 13'd4096;
  localparam logic [DEC_W-1:0]    MAX_DECIMATION = 4'd8;
  localparam logic [POS_W-1:0]    PAIRS_SAT      = 12'd4095;
  localparam logic [ROWCNT_W-1:0] ROWS_SAT       = 13'd8191;

  localparam logic [CFG_W-1:0] RST_LINE_WORDS = 13'd960;
  localparam logic [CFG_W-1:0] RST_OUT_WIDTH  = 13'd960;
  localparam logic [CFG_W-1:0] RST_OUT_HEIGHT = 13'd540;
  localparam logic [DEC_W-1:0] RST_DECIMATION = 4'd2;

  localparam logic signed [17:0] COEF_RV = 18'sd359;
  localparam logic signed [17:0] COEF_GU = 18'sd88;
  localparam logic signed [17:0] COEF_GV = 18'sd183;
  localparam logic signed [17:0] COEF_BU = 18'sd454;
  localparam logic signed [8:0]  CHROMA_OFFSET = 9'sd128;
  localparam logic signed [10:0] BYTE_MAX      = 11'sd255;
  localparam int unsigned        FRAC_BITS     = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WORDS = 2'd0,
    CFG_OUT_WIDTH  = 2'd1,
    CFG_OUT_HEIGHT = 2'd2,
    CFG_DECIMATION = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] luma_first;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] luma_second;
    logic [PIX_W-1:0] chroma_red;
  } yuyv_t;

  typedef struct packed {
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic             second_valid;
    logic             end_of_row;
  } meta_t;

  typedef struct packed {
    logic  valid;
    yuyv_t pix;
    meta_t meta;
  } stage_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

endpackage

>>> hdl/yrgb_if.sv
// ----------------------------------------------------------------------------
// yrgb_if
// valid/ready channels for yuyv words and rgb results
// ----------------------------------------------------------------------------
interface yrgb_in_if;
  import yrgb_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] luma_first;
  logic [PIX_W-1:0] chroma_blue;
  logic [PIX_W-1:0] luma_second;
  logic [PIX_W-1:0] chroma_red;
  logic             start_of_frame;

  modport source (
    output valid, luma_first, chroma_blue, luma_second, chroma_red, start_of_frame,
    input  ready
  );
  modport sink (
    input  valid, luma_first, chroma_blue, luma_second, chroma_red, start_of_frame,
    output ready
  );
endinterface

interface yrgb_out_if;
  import yrgb_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_first;
  logic [PIX_W-1:0] green_first;
  logic [PIX_W-1:0] blue_first;
  logic [PIX_W-1:0] red_second;
  logic [PIX_W-1:0] green_second;
  logic [PIX_W-1:0] blue_second;
  logic             second_valid;
  logic [POS_W-1:0] out_column;
  logic [POS_W-1:0] out_row;
  logic             end_of_row;

  modport source (
    output valid, red_first, green_first, blue_first, red_second, green_second,
           blue_second, second_valid, out_column, out_row, end_of_row,
    input  ready
  );
  modport sink (
    input  valid, red_first, green_first, blue_first, red_second, green_second,
           blue_second, second_valid, out_column, out_row, end_of_row,
    output ready
  );
endinterface

>>> hdl/yrgb_ctrl.sv
// ----------------------------------------------------------------------------
// yrgb_ctrl
// config registers, line and frame counters, decimation and input register
// ----------------------------------------------------------------------------
module yrgb_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  yrgb_pkg::cfg_idx_t                 cfg_index,
  input  logic [yrgb_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  yrgb_pkg::yuyv_t                    in_pix,
  input  logic                               in_sof,
  input  logic                               advance,
  output yrgb_pkg::stage_t                   stage
);
  import yrgb_pkg::*;

  logic [CFG_W-1:0]    line_words_r, out_width_r, out_height_r;
  logic [DEC_W-1:0]    decimation_r;
  logic [CFG_W-1:0]    lw, ow, oh;
  logic [DEC_W-1:0]    dec;

  logic [POS_W-1:0]    word_in_line_r, word_in_line_nxt, wil;
  logic [PHASE_W-1:0]  pair_phase_r, pair_phase_nxt, pp;
  logic [POS_W-1:0]    kept_pairs_r, kept_pairs_nxt, kp;
  logic [PHASE_W-1:0]  row_phase_r, row_phase_nxt, rp;
  logic [ROWCNT_W-1:0] kept_rows_r, kept_rows_nxt, kr;

  logic [CFG_W:0]      col;
  logic                keep, line_end, accept;
  stage_t              stage_r, stage_nxt;

  // effective register values
  always_comb begin
    if (line_words_r == '0) begin
      lw = CFG_W'(1);
    end else if (line_words_r > MAX_LINE_WORDS) begin
      lw = MAX_LINE_WORDS;
    end else begin
      lw = line_words_r;
    end
    if (decimation_r == '0) begin
      dec = DEC_W'(1);
    end else if (decimation_r > MAX_DECIMATION) begin
      dec = MAX_DECIMATION;
    end else begin
      dec = decimation_r;
    end
    ow = (out_width_r > MAX_WIDTH) ? MAX_WIDTH : out_width_r;
    oh = (out_height_r > MAX_ROWS) ? MAX_ROWS : out_height_r;
  end

  assign accept   = in_valid && in_ready;
  assign in_ready = !stage_r.valid || advance;

  // counters after start of frame clear
  always_comb begin
    wil = in_sof ? '0 : word_in_line_r;
    pp  = in_sof ? '0 : pair_phase_r;
    kp  = in_sof ? '0 : kept_pairs_r;
    rp  = in_sof ? '0 : row_phase_r;
    kr  = in_sof ? '0 : kept_rows_r;
  end

  assign col  = {1'b0, kp, 1'b0};
  assign keep = (rp == '0) && (pp == '0) && (kr < oh) && (col < {1'b0, ow});

  always_comb begin
    stage_nxt = stage_r;
    if (accept) begin
      stage_nxt.valid             = keep;
      stage_nxt.pix               = in_pix;
      stage_nxt.meta.column       = col[POS_W-1:0];
      stage_nxt.meta.row          = kr[POS_W-1:0];
      stage_nxt.meta.second_valid = (col + (CFG_W+1)'(1)) < {1'b0, ow};
      stage_nxt.meta.end_of_row   = ((col + (CFG_W+1)'(2)) >= {1'b0, ow})
                                  || (({1'b0, wil} + CFG_W'(dec)) >= lw);
    end else if (advance) begin
      stage_nxt.valid = 1'b0;
    end
  end

  assign line_end = ({1'b0, wil} + CFG_W'(1)) >= lw;

  always_comb begin
    kept_pairs_nxt   = ((pp == '0) && (kp != PAIRS_SAT)) ? kp + POS_W'(1) : kp;
    pair_phase_nxt   = (({1'b0, pp} + DEC_W'(1)) >= dec) ? '0 : pp + PHASE_W'(1);
    word_in_line_nxt = wil + POS_W'(1);
    row_phase_nxt    = rp;
    kept_rows_nxt    = kr;
    if (line_end) begin
      word_in_line_nxt = '0;
      pair_phase_nxt   = '0;
      kept_pairs_nxt   = '0;
      if ((rp == '0) && (kr != ROWS_SAT)) begin
        kept_rows_nxt = kr + ROWCNT_W'(1);
      end
      row_phase_nxt = (({1'b0, rp} + DEC_W'(1)) >= dec) ? '0 : rp + PHASE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_words_r   <= RST_LINE_WORDS;
      out_width_r    <= RST_OUT_WIDTH;
      out_height_r   <= RST_OUT_HEIGHT;
      decimation_r   <= RST_DECIMATION;
      word_in_line_r <= '0;
      pair_phase_r   <= '0;
      kept_pairs_r   <= '0;
      row_phase_r    <= '0;
      kept_rows_r    <= '0;
      stage_r.valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LINE_WORDS: line_words_r <= cfg_data;
          CFG_OUT_WIDTH:  out_width_r  <= cfg_data;
          CFG_OUT_HEIGHT: out_height_r <= cfg_data;
          CFG_DECIMATION: decimation_r <= cfg_data[DEC_W-1:0];
        endcase
      end
      if (accept) begin
        word_in_line_r <= word_in_line_nxt;
        pair_phase_r   <= pair_phase_nxt;
        kept_pairs_r   <= kept_pairs_nxt;
        row_phase_r    <= row_phase_nxt;
        kept_rows_r    <= kept_rows_nxt;
      end
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.pix  <= stage_nxt.pix;
    stage_r.meta <= stage_nxt.meta;
  end

  assign stage = stage_r;

endmodule

>>> hdl/yrgb_conv.sv
// ----------------------------------------------------------------------------
// yrgb_conv
// integer bt.601 conversion of one yuyv pair to two rgb pixels
// ----------------------------------------------------------------------------
module yrgb_conv (
  input  yrgb_pkg::yuyv_t pix,
  input  logic            second_valid,
  output yrgb_pkg::rgb_t  rgb_first,
  output yrgb_pkg::rgb_t  rgb_second
);
  import yrgb_pkg::*;

  logic signed [8:0]  u, v;
  logic signed [17:0] u_ext, v_ext;
  logic signed [17:0] r_prod, g_prod, b_prod;
  logic signed [9:0]  r_off, g_off, b_off;

  function automatic logic [PIX_W-1:0] clamp_byte(input logic signed [10:0] s);
    logic [PIX_W-1:0] res;
    if (s < 11'sd0) begin
      res = '0;
    end else if (s > BYTE_MAX) begin
      res = BYTE_MAX[PIX_W-1:0];
    end else begin
      res = s[PIX_W-1:0];
    end
    return res;
  endfunction

  function automatic rgb_t make_pixel(input logic [PIX_W-1:0] y,
                                      input logic signed [9:0] ro,
                                      input logic signed [9:0] go,
                                      input logic signed [9:0] bo);
    logic signed [10:0] ys;
    rgb_t               px;
    ys       = $signed({3'b000, y});
    px.red   = clamp_byte(ys + 11'(ro));
    px.green = clamp_byte(ys - 11'(go));
    px.blue  = clamp_byte(ys + 11'(bo));
    return px;
  endfunction

  assign u      = $signed({1'b0, pix.chroma_blue}) - CHROMA_OFFSET;
  assign v      = $signed({1'b0, pix.chroma_red}) - CHROMA_OFFSET;
  assign u_ext  = 18'(u);
  assign v_ext  = 18'(v);
  assign r_prod = v_ext * COEF_RV;
  assign g_prod = u_ext * COEF_GU + v_ext * COEF_GV;
  assign b_prod = u_ext * COEF_BU;

  // arithmetic shift, rounds toward minus infinity
  assign r_off = r_prod[17:FRAC_BITS];
  assign g_off = g_prod[17:FRAC_BITS];
  assign b_off = b_prod[17:FRAC_BITS];

  assign rgb_first  = make_pixel(pix.luma_first, r_off, g_off, b_off);
  assign rgb_second = second_valid ? make_pixel(pix.luma_second, r_off, g_off, b_off)
                                   : '0;

endmodule

>>> hdl/yuyv_to_rgb_decimating.sv
// ----------------------------------------------------------------------------
// yuyv_to_rgb_decimating
// decimating yuyv to rgb converter, top level
// ----------------------------------------------------------------------------
// Takes one YUYV pair word per cycle, with no gaps between words, while the
// result register is empty or read by the sink; words that fall outside the
// kept grid are consumed without a result. The line and frame counters tag a
// kept word with its output position on its way into the input register, and
// the constant-coefficient color math runs from there into the result
// register once it is free or being read. While a result waits for the sink the
// input register still takes one more word; only then does the input stall.
// There is no clearing pass after reset.
`include "yuyv_to_rgb_decimating_macros.svh"

module yuyv_to_rgb_decimating (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  yrgb_pkg::cfg_idx_t         cfg_index,
  input  logic [yrgb_pkg::CFG_W-1:0] cfg_data,
  yrgb_in_if.sink                    in_chan,
  yrgb_out_if.source                 out_chan
);
  import yrgb_pkg::*;

  yuyv_t  in_pix;
  stage_t stage;
  rgb_t   rgb_first, rgb_second;
  rgb_t   first_r, second_r;
  meta_t  meta_r;
  logic   out_valid_r, out_valid_nxt;
  logic   advance;

  assign in_pix = '{luma_first:  in_chan.luma_first,
                    chroma_blue: in_chan.chroma_blue,
                    luma_second: in_chan.luma_second,
                    chroma_red:  in_chan.chroma_red};

  assign advance = stage.valid && (!out_valid_r || out_chan.ready);

  yrgb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_pix    (in_pix),
    .in_sof    (in_chan.start_of_frame),
    .advance   (advance),
    .stage     (stage)
  );

  yrgb_conv u_conv (
    .pix          (stage.pix),
    .second_valid (stage.meta.second_valid),
    .rgb_first    (rgb_first),
    .rgb_second   (rgb_second)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (advance) begin
      first_r  <= rgb_first;
      second_r <= rgb_second;
      meta_r   <= stage.meta;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.red_first    = first_r.red;
  assign out_chan.green_first  = first_r.green;
  assign out_chan.blue_first   = first_r.blue;
  assign out_chan.red_second   = second_r.red;
  assign out_chan.green_second = second_r.green;
  assign out_chan.blue_second  = second_r.blue;
  assign out_chan.second_valid = meta_r.second_valid;
  assign out_chan.out_column   = meta_r.column;
  assign out_chan.out_row      = meta_r.row;
  assign out_chan.end_of_row   = meta_r.end_of_row;

  `YRGB_ASSERT_SAME(a_second_blank, out_valid_r && !meta_r.second_valid, second_r == '0, "second pixel not blanked")
  `YRGB_ASSERT_SAME(a_no_overrun, stage.valid && out_valid_r && !out_chan.ready, !in_chan.ready, "input taken while pipeline full")
  `YRGB_ASSERT_NEXT(a_result_loaded, advance, out_valid_r, "stage moved but no result held")
  `YRGB_ASSERT_SAME(a_even_column, out_valid_r, !meta_r.column[0], "odd first column")

endmodule

>>> tb/tb_yuyv_to_rgb_decimating.sv
// ----------------------------------------------------------------------------
// tb_yuyv_to_rgb_decimating
// self-checking testbench of the decimating yuyv to rgb converter
// ----------------------------------------------------------------------------
// Drives pair words through the input channel and predicts every kept pixel
// pair with an independent model of the line, row and decimation counters and
// of the integer color math. Each result word is compared field by field with
// the oldest prediction. Directed tests cover color corners, odd widths,
// short lines, zero and oversized registers and the largest sizes; random
// frames then run under several idle and stall mixes and a long sink hold-off.

module tb_yuyv_to_rgb_decimating;
  timeunit 1ns;
  timeprecision 1ps;

  import yrgb_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    logic [PIX_W-1:0] red_first;
    logic [PIX_W-1:0] green_first;
    logic [PIX_W-1:0] blue_first;
    logic [PIX_W-1:0] red_second;
    logic [PIX_W-1:0] green_second;
    logic [PIX_W-1:0] blue_second;
    logic             second_valid;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic             end_of_row;
  } pixel_result_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  cfg_idx_t         cfg_index;
  logic [CFG_W-1:0] cfg_data;

  yrgb_in_if  in_chan ();
  yrgb_out_if out_chan ();

  yuyv_to_rgb_decimating u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  int cfg_line_words = int'(RST_LINE_WORDS);
  int cfg_out_width  = int'(RST_OUT_WIDTH);
  int cfg_out_height = int'(RST_OUT_HEIGHT);
  int cfg_decimation = int'(RST_DECIMATION);

  int word_in_line = 0;
  int pair_phase   = 0;
  int kept_pairs   = 0;
  int row_phase    = 0;
  int kept_rows    = 0;

  pixel_result_t expected_pixels[$];

  int src_idle_pct    = 0;
  int sink_stall_pct  = 0;
  int hold_requests   = 0;
  int hold_served     = 0;
  int hold_left       = 0;
  int mismatch_count  = 0;
  int kept_word_count = 0;
  int cycle_count     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [PIX_W-1:0] clamp_byte(input int x);
    if (x < 0) return '0;
    if (x > int'(BYTE_MAX)) return PIX_W'(BYTE_MAX);
    return PIX_W'(x);
  endfunction

  function automatic bit predict_pair(input yuyv_t w, input bit sof,
                                      output pixel_result_t px);
    int lw, dec, ow, oh, u, v, r_off, g_off, b_off, col;
    bit kept;
    lw  = (cfg_line_words < 1) ? 1 :
          (cfg_line_words > int'(MAX_LINE_WORDS)) ? int'(MAX_LINE_WORDS) : cfg_line_words;
    dec = (cfg_decimation < 1) ? 1 :
          (cfg_decimation > int'(MAX_DECIMATION)) ? int'(MAX_DECIMATION) : cfg_decimation;
    ow  = (cfg_out_width > int'(MAX_WIDTH)) ? int'(MAX_WIDTH) : cfg_out_width;
    oh  = (cfg_out_height > int'(MAX_ROWS)) ? int'(MAX_ROWS) : cfg_out_height;
    if (sof) begin
      word_in_line = 0;
      pair_phase   = 0;
      kept_pairs   = 0;
      row_phase    = 0;
      kept_rows    = 0;
    end
    px   = '0;
    kept = (row_phase == 0) && (pair_phase == 0) && (kept_rows < oh) &&
           (2 * kept_pairs < ow);
    if (kept) begin
      u     = int'(w.chroma_blue) - int'(CHROMA_OFFSET);
      v     = int'(w.chroma_red) - int'(CHROMA_OFFSET);
      r_off = (int'(COEF_RV) * v) >>> FRAC_BITS;
      g_off = (int'(COEF_GU) * u + int'(COEF_GV) * v) >>> FRAC_BITS;
      b_off = (int'(COEF_BU) * u) >>> FRAC_BITS;
      col   = 2 * kept_pairs;
      px.red_first   = clamp_byte(int'(w.luma_first) + r_off);
      px.green_first = clamp_byte(int'(w.luma_first) - g_off);
      px.blue_first  = clamp_byte(int'(w.luma_first) + b_off);
      if (col + 1 < ow) begin
        px.red_second   = clamp_byte(int'(w.luma_second) + r_off);
        px.green_second = clamp_byte(int'(w.luma_second) - g_off);
        px.blue_second  = clamp_byte(int'(w.luma_second) + b_off);
        px.second_valid = 1'b1;
      end
      px.column     = POS_W'(col);
      px.row        = POS_W'(kept_rows);
      px.end_of_row = (col + 2 >= ow) || (word_in_line + dec >= lw);
    end
    if (pair_phase == 0 && kept_pairs < int'(PAIRS_SAT)) kept_pairs++;
    pair_phase = (pair_phase + 1 >= dec) ? 0 : pair_phase + 1;
    if (word_in_line + 1 >= lw) begin
      word_in_line = 0;
      pair_phase   = 0;
      kept_pairs   = 0;
      if (row_phase == 0 && kept_rows < int'(ROWS_SAT)) kept_rows++;
      row_phase = (row_phase + 1 >= dec) ? 0 : row_phase + 1;
    end else begin
      word_in_line = (word_in_line + 1) & 32'hFFF;
    end
    return kept;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("mismatch %s: got %0d, expected %0d, cycle %0d", what, got, want,
               cycle_count);
  endtask

  task automatic check_field(input string name, input logic [POS_W-1:0] got,
                             input logic [POS_W-1:0] want);
    if (got !== want) report_mismatch(name, int'(got), int'(want));
  endtask

  task automatic send_word(input yuyv_t w, input bit sof);
    pixel_result_t px;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.luma_first     <= w.luma_first;
    in_chan.chroma_blue    <= w.chroma_blue;
    in_chan.luma_second    <= w.luma_second;
    in_chan.chroma_red     <= w.chroma_red;
    in_chan.start_of_frame <= sof;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    if (predict_pair(w, sof, px)) begin
      expected_pixels.push_back(px);
      kept_word_count++;
    end
  endtask

  task automatic send_random(input int count, input bit first_sof);
    for (int i = 0; i < count; i++)
      send_word(yuyv_t'($urandom), first_sof && (i == 0));
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    case (idx)
      CFG_LINE_WORDS: cfg_line_words = value & 32'h1FFF;
      CFG_OUT_WIDTH:  cfg_out_width  = value & 32'h1FFF;
      CFG_OUT_HEIGHT: cfg_out_height = value & 32'h1FFF;
      CFG_DECIMATION: cfg_decimation = value & 32'hF;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input int lw, input int ow, input int oh, input int dec);
    wait_idle();
    write_reg(CFG_LINE_WORDS, lw);
    write_reg(CFG_OUT_WIDTH, ow);
    write_reg(CFG_OUT_HEIGHT, oh);
    write_reg(CFG_DECIMATION, dec);
  endtask

  task automatic test_color_extremes();
    logic [31:0] corner_pairs [10] = '{
      32'h00000000, 32'hFFFFFFFF, 32'hFF00FF00, 32'h00FF00FF, 32'h80808080,
      32'h0080FF80, 32'hFFFF0000, 32'h0000FFFF, 32'h1080EB80, 32'h29F0D210
    };
    set_config(4, 8, 4, 1);
    for (int i = 0; i < 10; i++) send_word(yuyv_t'(corner_pairs[i]), i == 0);
  endtask

  task automatic test_row_edges();
    // odd width drops the second pixel, then frame complete
    set_config(3, 5, 2, 1);
    send_random(9, 1'b1);
    // line shorter than the output width
    set_config(2, 8, 3, 1);
    send_random(4, 1'b1);
    // registers changed in the middle of a frame
    set_config(5, 10, 3, 2);
    send_random(5, 1'b0);
  endtask

  task automatic test_register_limits();
    set_config(0, 4, 3, 0);
    send_random(8, 1'b1);
    set_config(4, 0, 3, 1);
    send_random(6, 1'b1);
    set_config(4, 4, 0, 1);
    send_random(6, 1'b1);
    set_config(8191, 8191, 8191, 15);
    send_random(40, 1'b1);
    set_config(4096, 4096, 4096, 8);
    send_random(20, 1'b1);
  endtask

  task automatic test_full_width_row();
    set_config(4096, 4096, 1, 1);
    send_random(40, 1'b1);
  endtask

  task automatic test_full_height_column();
    set_config(1, 2, 8191, 1);
    send_random(40, 1'b1);
  endtask

  task automatic test_random_frames(input int src_pct, input int sink_pct,
                                    input int target);
    int sent, lw, ow, oh, dec, dec_eff, rows, words;
    bit sof;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    sent           = 0;
    while (sent < target) begin
      lw = $urandom_range(1, 12);
      if ($urandom_range(0, 9) == 0) lw = 0;
      dec = $urandom_range(1, 4);
      if ($urandom_range(0, 5) == 0) dec = $urandom_range(0, 8);
      ow = $urandom_range(1, 26);
      oh = $urandom_range(1, 5);
      set_config(lw, ow, oh, dec);
      dec_eff = (dec < 1) ? 1 : dec;
      repeat ($urandom_range(1, 3)) begin
        rows  = $urandom_range(1, oh * dec_eff + 2);
        words = ((lw < 1) ? 1 : lw) * rows;
        for (int i = 0; i < words && sent < target; i++) begin
          // mostly clean frames, some missing or stray frame starts
          sof = (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 59) == 0);
          send_word(yuyv_t'($urandom), sof);
          sent++;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    set_config(4, 8, 20, 1);
    hold_requests++;
    send_random(60, 1'b1);
    // sender pauses until every result is out
    wait_idle();
    send_random(20, 1'b0);
  endtask

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_chan.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_chan.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    pixel_result_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = expected_pixels.pop_front();
        check_field("red_first", POS_W'(out_chan.red_first), POS_W'(want.red_first));
        check_field("green_first", POS_W'(out_chan.green_first),
                    POS_W'(want.green_first));
        check_field("blue_first", POS_W'(out_chan.blue_first), POS_W'(want.blue_first));
        check_field("red_second", POS_W'(out_chan.red_second), POS_W'(want.red_second));
        check_field("green_second", POS_W'(out_chan.green_second),
                    POS_W'(want.green_second));
        check_field("blue_second", POS_W'(out_chan.blue_second),
                    POS_W'(want.blue_second));
        check_field("second_valid", POS_W'(out_chan.second_valid),
                    POS_W'(want.second_valid));
        check_field("out_column", out_chan.out_column, want.column);
        check_field("out_row", out_chan.out_row, want.row);
        check_field("end_of_row", POS_W'(out_chan.end_of_row), POS_W'(want.end_of_row));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n                  <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_index              <= CFG_LINE_WORDS;
    cfg_data               <= '0;
    in_chan.valid          <= 1'b0;
    in_chan.luma_first     <= '0;
    in_chan.chroma_blue    <= '0;
    in_chan.luma_second    <= '0;
    in_chan.chroma_red     <= '0;
    in_chan.start_of_frame <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_color_extremes();
    test_row_edges();
    test_register_limits();
    test_full_width_row();
    test_full_height_column();
    test_random_frames(0, 0, 45);
    test_random_frames(81, 0, 45);
    test_random_frames(0, 81, 45);
    test_random_frames(34, 34, 45);
    test_backpressure();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
